FILE: rtl/core/rtcp_sdes_item_parser_macros.svh
// Assertion helpers for the SDES item parser.
`ifndef RTCP_SDES_ITEM_PARSER_MACROS_SVH
`define RTCP_SDES_ITEM_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define RSDES_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("rtcp sdes parser check failed");
`define RSDES_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("rtcp sdes parser sequence check failed");
`else
`define RSDES_ASSERT(lbl, clk_s, rst_s, prop)
`define RSDES_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

FILE: rtl/core/rsdes_pkg.sv
package rsdes_pkg;

  localparam int MAX_CHUNK_BYTES_DEF = 1024;

  // SDES item type codes
  localparam logic [7:0] SDES_END   = 8'd0;
  localparam logic [7:0] SDES_CNAME = 8'd1;
  localparam logic [7:0] SDES_NAME  = 8'd2;
  localparam logic [7:0] SDES_EMAIL = 8'd3;
  localparam logic [7:0] SDES_TOOL  = 8'd6;

  // Item kinds; the report shares its code with the end item
  localparam logic [2:0] KIND_NAME    = 3'd0;
  localparam logic [2:0] KIND_EMAIL   = 3'd1;
  localparam logic [2:0] KIND_TOOL    = 3'd2;
  localparam logic [2:0] KIND_CNAME   = 3'd3;
  localparam logic [2:0] KIND_ZERO    = 3'd4;
  localparam logic [2:0] KIND_UNKNOWN = 3'd5;
  localparam logic [2:0] KIND_REPORT  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNKNOWN   = 2'd1;
  localparam logic [1:0] ST_BAD_CNAME = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // CNAME field phases: even ones from 2 to 12 wait for the first digit of a number
  localparam logic [3:0] CF_USER_START = 4'd0;
  localparam logic [3:0] CF_USER       = 4'd1;
  localparam logic [3:0] CF_OCT1_START = 4'd2;
  localparam logic [3:0] CF_OCT1       = 4'd3;
  localparam logic [3:0] CF_OCT2       = 4'd5;
  localparam logic [3:0] CF_OCT3       = 4'd7;
  localparam logic [3:0] CF_OCT4       = 4'd9;
  localparam logic [3:0] CF_PORT_START = 4'd10;
  localparam logic [3:0] CF_PORT       = 4'd11;
  localparam logic [3:0] CF_TIME_START = 4'd12;
  localparam logic [3:0] CF_TIME       = 4'd13;
  localparam logic [3:0] CF_GOOD       = 4'd14;
  localparam logic [3:0] CF_BAD        = 4'd15;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_TYPE = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_BAD  = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [31:0] num;
    logic [31:0] ip;
    logic [15:0] port;
  } cname_acc_t;

  function automatic logic [2:0] type_to_kind(logic [7:0] t);
    logic [2:0] k;
    unique case (t)
      SDES_NAME:  k = KIND_NAME;
      SDES_EMAIL: k = KIND_EMAIL;
      SDES_TOOL:  k = KIND_TOOL;
      SDES_CNAME: k = KIND_CNAME;
      SDES_END:   k = KIND_ZERO;
      default:    k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // One CNAME character: user@a.b.c.d/port/time, digits only
  function automatic cname_acc_t cname_feed(cname_acc_t a, logic [7:0] c);
    cname_acc_t  r;
    logic        dig;
    logic [31:0] times10;
    logic [31:0] shifted;
    r       = a;
    dig     = (c >= CH_ZERO) && (c <= CH_NINE);
    times10 = {a.num[28:0], 3'b000} + {a.num[30:0], 1'b0};
    unique case (a.phase)
      CF_OCT1: shifted = {a.num[7:0], 24'd0};
      CF_OCT2: shifted = {a.num[15:0], 16'd0};
      default: shifted = {a.num[23:0], 8'd0};
    endcase
    if (a.phase == CF_USER_START) begin
      r.phase = ((c == CH_NUL) || (c == CH_AT)) ? CF_BAD : CF_USER;
    end else if (a.phase == CF_USER) begin
      if (c == CH_NUL) begin
        r.phase = CF_BAD;
      end else if (c == CH_AT) begin
        r.phase = CF_OCT1_START;
      end
    end else if ((a.phase <= CF_TIME_START) && !a.phase[0]) begin
      if (dig) begin
        r.num   = {28'd0, c[3:0]};
        r.phase = a.phase + 4'd1;
      end else begin
        r.phase = CF_BAD;
      end
    end else if (a.phase <= CF_TIME) begin
      if (dig) begin
        r.num = times10 + {28'd0, c[3:0]};
      end else if (a.phase == CF_TIME) begin
        r.phase = CF_GOOD;
      end else if ((a.phase <= CF_OCT3) && (c == CH_DOT)) begin
        r.ip    = a.ip | shifted;
        r.phase = a.phase + 4'd1;
      end else if ((a.phase == CF_OCT4) && (c == CH_SLASH)) begin
        r.ip    = a.ip | a.num;
        r.phase = CF_PORT_START;
      end else if ((a.phase == CF_PORT) && (c == CH_SLASH)) begin
        r.port  = a.num[15:0];
        r.phase = CF_TIME_START;
      end else begin
        r.phase = CF_BAD;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/rtcp_sdes_item_parser.sv
// SDES chunk item parser: one chunk byte per word, one result word at most per byte.
// Each accepted byte goes through the input register, then the parse logic into the
// result register.
// Throughput: one byte per cycle; while a result waits the input register holds one
// more byte, then stalls the input. Reset (rst, synchronous) empties both registers
// and idles the parser.
`include "rtcp_sdes_item_parser_macros.svh"

module rtcp_sdes_item_parser
  import rsdes_pkg::*;
#(
  parameter int MAX_CHUNK_BYTES = MAX_CHUNK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic [10:0] chunk_length,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  result_kind,
  output logic [7:0]  text_byte,
  output logic [1:0]  parse_status,
  output logic [31:0] source_ip,
  output logic [15:0] rtp_port,
  output logic [15:0] rtcp_port,
  output logic [31:0] start_time,
  output logic        cname_seen
);

  // Remaining-byte counter sized to hold the largest chunk
  localparam int BL_W  = $clog2(MAX_CHUNK_BYTES + 1);
  localparam int CMP_W = (BL_W > 11) ? BL_W : 11;
  localparam int LT_W  = ((BL_W > 8) ? BL_W : 8) + 1;

  // Input register
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_first;
  logic [10:0] s1_length;

  // Parser state
  phase_t      phase, phase_next;
  logic [BL_W-1:0] bytes_left, bytes_left_next;
  logic [2:0]  item_kind, item_kind_next;
  logic [7:0]  item_bytes_left, item_bytes_left_next;
  cname_acc_t  cname_acc, cname_acc_next;
  logic [31:0] decoded_ip, decoded_ip_next;
  logic [15:0] decoded_port, decoded_port_next;
  logic [31:0] decoded_time, decoded_time_next;
  logic        cname_valid, cname_valid_next;

  logic        res_emit;
  logic [2:0]  res_kind;
  logic [7:0]  res_text;
  logic [1:0]  res_status;

  logic        out_free;
  logic        process;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] len_max;
  logic [CMP_W-1:0] len_clamped;

  // The result register frees when it is empty or its word is taken this cycle.
  assign out_free   = !result_valid || !result_stall;
  assign data_stall = s1_valid && !out_free;
  assign process    = s1_valid && out_free;

  assign len_ext     = CMP_W'(s1_length);
  assign len_max     = CMP_W'(MAX_CHUNK_BYTES);
  assign len_clamped = (len_ext > len_max) ? len_max : len_ext;

  // last_byte is carried by the channel but chunk_length alone bounds the chunk.

  always_comb begin
    phase_next           = phase;
    bytes_left_next      = bytes_left;
    item_kind_next       = item_kind;
    item_bytes_left_next = item_bytes_left;
    cname_acc_next       = cname_acc;
    decoded_ip_next      = decoded_ip;
    decoded_port_next    = decoded_port;
    decoded_time_next    = decoded_time;
    cname_valid_next     = cname_valid;
    res_emit             = 1'b0;
    res_kind             = KIND_REPORT;
    res_text             = 8'd0;
    res_status           = ST_OK;

    // A first byte restarts the chunk from any phase, then parses as a type byte.
    if (s1_first) begin
      phase_next           = PH_TYPE;
      bytes_left_next      = len_clamped[BL_W-1:0];
      item_kind_next       = KIND_NAME;
      item_bytes_left_next = 8'd0;
      cname_acc_next       = '0;
      decoded_ip_next      = 32'd0;
      decoded_port_next    = 16'd0;
      decoded_time_next    = 32'd0;
      cname_valid_next     = 1'b0;
    end

    unique case (phase_next)
      PH_TYPE: begin
        // Too little room left for another item: close the chunk.
        if (bytes_left_next <= BL_W'(3)) begin
          phase_next = PH_DONE;
          res_emit   = 1'b1;
        end else begin
          bytes_left_next = bytes_left_next - BL_W'(1);
          item_kind_next  = type_to_kind(s1_byte);
          phase_next      = PH_LEN;
        end
      end
      PH_LEN: begin
        // Length test comes before the type is judged.
        if (!((LT_W'(s1_byte) + LT_W'(1)) < LT_W'(bytes_left_next)) ||
            (item_kind_next == KIND_ZERO)) begin
          phase_next = PH_DONE;
          res_emit   = 1'b1;
        end else if (item_kind_next == KIND_UNKNOWN) begin
          phase_next = PH_DONE;
          res_emit   = 1'b1;
          res_status = ST_UNKNOWN;
        end else begin
          bytes_left_next = bytes_left_next - BL_W'(1);
          if (s1_byte == 8'd0) begin
            // Empty CNAME is malformed; other empty items are skipped.
            if (item_kind_next == KIND_CNAME) begin
              phase_next = PH_DONE;
              res_emit   = 1'b1;
              res_status = ST_BAD_CNAME;
            end else begin
              phase_next = PH_TYPE;
            end
          end else begin
            item_bytes_left_next = s1_byte;
            cname_acc_next       = '0;
            phase_next           = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (bytes_left_next != '0) begin
          bytes_left_next = bytes_left_next - BL_W'(1);
        end
        if (item_kind_next == KIND_CNAME) begin
          cname_acc_next = cname_feed(cname_acc_next, s1_byte);
        end
        if (item_bytes_left_next != 8'd0) begin
          item_bytes_left_next = item_bytes_left_next - 8'd1;
        end
        if (item_bytes_left_next == 8'd0) begin
          phase_next = PH_TYPE;
          if (item_kind_next == KIND_CNAME) begin
            // Commit the decode, or flag a malformed CNAME for the next byte.
            if ((cname_acc_next.phase == CF_TIME) || (cname_acc_next.phase == CF_GOOD)) begin
              decoded_ip_next   = cname_acc_next.ip;
              decoded_port_next = cname_acc_next.port;
              decoded_time_next = cname_acc_next.num;
              cname_valid_next  = 1'b1;
            end else begin
              phase_next = PH_BAD;
            end
          end
        end
        res_emit = 1'b1;
        res_kind = item_kind_next;
        res_text = s1_byte;
      end
      PH_BAD: begin
        phase_next = PH_DONE;
        res_emit   = 1'b1;
        res_status = ST_BAD_CNAME;
      end
      default: begin
        // Idle before a first byte, done after the report: drop the byte.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!data_stall) begin
      s1_valid <= data_valid;
    end
    if (data_valid && !data_stall) begin
      s1_byte   <= data_byte;
      s1_first  <= first_byte;
      s1_length <= chunk_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (process) begin
      phase <= phase_next;
    end
    if (process) begin
      bytes_left      <= bytes_left_next;
      item_kind       <= item_kind_next;
      item_bytes_left <= item_bytes_left_next;
      cname_acc       <= cname_acc_next;
      decoded_ip      <= decoded_ip_next;
      decoded_port    <= decoded_port_next;
      decoded_time    <= decoded_time_next;
      cname_valid     <= cname_valid_next;
    end
  end

  // Result register: load on a parsed byte that yields a word, else empty when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= process && res_emit;
    end
    if (process && res_emit) begin
      result_kind  <= res_kind;
      text_byte    <= res_text;
      parse_status <= res_status;
      source_ip    <= decoded_ip_next;
      rtp_port     <= decoded_port_next;
      rtcp_port    <= decoded_port_next + 16'd1;
      start_time   <= decoded_time_next;
      cname_seen   <= cname_valid_next;
    end
  end

  `RSDES_ASSERT(a_text_status_ok, clk, rst,
                result_valid && (result_kind != KIND_REPORT) |-> parse_status == ST_OK)
  `RSDES_ASSERT(a_rtcp_port, clk, rst, result_valid |-> rtcp_port == 16'(rtp_port + 16'd1))
  `RSDES_ASSERT(a_no_cname_zero, clk, rst,
                result_valid && !cname_seen |-> (source_ip == 32'd0) && (start_time == 32'd0))
  `RSDES_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && data_stall, s1_valid && $stable(s1_byte))

endmodule
